>>> src/bgmu_pkg.sv
// Shared types and constants for the binary grid majority update block.
// Used by bgmu_core and binary_grid_majority_update; no dependencies.
`timescale 1ns / 1ps

package bgmu_pkg;

    // Grid geometry (power of two, so a cell address is {row, column})
    localparam int GRID_MAX = 64;
    localparam int IDX_W    = $clog2(GRID_MAX);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int CELLS    = GRID_MAX * GRID_MAX;

    // Field widths
    localparam int SIZE_W = 7;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int NB_W   = 4;
    localparam int WCNT_W = 32;
    localparam int STEP_W = 4;

    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(GRID_MAX);

    // Read sequence: step 0 is the addressed cell, steps 1..8 its neighbours
    localparam logic [STEP_W-1:0] STEP_TARGET = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(8);

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Offset of a neighbour along one axis
    typedef enum logic [1:0] {
        OFF_MINUS,
        OFF_ZERO,
        OFF_PLUS
    } off_t;

    typedef struct packed {
        logic              clear;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  cells;
    } cfg_t;

    typedef struct packed {
        logic              new_value;
        logic [NB_W-1:0]   zero_neighbours;
        logic [NB_W-1:0]   one_neighbours;
        logic [CNT_W-1:0]  ones_total;
        logic              uniform;
        logic [WCNT_W-1:0] zero_writes;
        logic [WCNT_W-1:0] one_writes;
    } result_t;

endpackage

>>> src/bgmu_core.sv
// Sequencer, grid memory and counters of the majority update block.
// Depends on bgmu_pkg.
`timescale 1ns / 1ps

module bgmu_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bgmu_pkg::cfg_t                  cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_kind,
    input  logic [bgmu_pkg::IDX_W-1:0]      in_row,
    input  logic [bgmu_pkg::IDX_W-1:0]      in_column,
    input  logic                            in_load_value,
    output logic                            res_valid,
    input  logic                            res_free,
    output bgmu_pkg::result_t               res
);
    import bgmu_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] pos;
    } coord_t;

    // Step one coordinate by an offset and check it against the grid side
    function automatic coord_t step_coord(input logic [IDX_W-1:0] p, input off_t o,
                                          input logic [SIZE_W-1:0] gs);
        coord_t            c;
        logic [SIZE_W-1:0] up;
        c  = '{ok: 1'b1, pos: p};
        up = SIZE_W'(p) + SIZE_W'(1);
        case (o)
            OFF_MINUS:
            begin
                c.ok  = (p != '0);
                c.pos = p - IDX_W'(1);
            end
            OFF_PLUS:
            begin
                c.ok  = (up < gs);
                c.pos = up[IDX_W-1:0];
            end
            default:
            begin
                c.ok  = 1'b1;
                c.pos = p;
            end
        endcase
        return c;
    endfunction

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              kind_reg, kind_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              lv_reg, lv_next;
    logic              old_reg, old_next;
    logic              nv_reg, nv_next;
    logic [NB_W-1:0]   zero_cnt_reg, zero_cnt_next;
    logic [NB_W-1:0]   one_cnt_reg, one_cnt_next;
    logic [CNT_W-1:0]  ones_reg, ones_next;
    logic [WCNT_W-1:0] zero_wr_reg, zero_wr_next;
    logic [WCNT_W-1:0] one_wr_reg, one_wr_next;

    // read pipeline: a read issued last cycle delivers its data now
    logic pend_valid_reg, pend_valid_next;
    logic pend_tgt_reg, pend_tgt_next;
    logic pend_in_reg, pend_in_next;

    // grid memory, one port
    logic              mem [CELLS];
    logic              mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_wdata;

    logic              accept;
    logic              in_grid;
    logic [STEP_W-1:0] last_step;
    off_t              dr, dc;
    coord_t            nr, nc;
    logic              nb_ok;
    logic              nv_calc;

    assign accept    = in_valid && in_ready;
    assign in_grid   = (SIZE_W'(in_row) < cfg.size) && (SIZE_W'(in_column) < cfg.size);
    assign last_step = (kind_reg == KIND_UPDATE) ? STEP_LAST : STEP_TARGET;
    assign nv_calc   = (kind_reg == KIND_UPDATE) ? (one_cnt_reg > zero_cnt_reg) : lv_reg;

    // Neighbour offsets for the current step
    always_comb
    begin
        dr = OFF_ZERO;
        dc = OFF_ZERO;
        unique case (step_reg)
            STEP_W'(1): begin dr = OFF_MINUS; dc = OFF_MINUS; end
            STEP_W'(2): begin dr = OFF_MINUS; dc = OFF_ZERO;  end
            STEP_W'(3): begin dr = OFF_MINUS; dc = OFF_PLUS;  end
            STEP_W'(4): begin dr = OFF_ZERO;  dc = OFF_MINUS; end
            STEP_W'(5): begin dr = OFF_ZERO;  dc = OFF_PLUS;  end
            STEP_W'(6): begin dr = OFF_PLUS;  dc = OFF_MINUS; end
            STEP_W'(7): begin dr = OFF_PLUS;  dc = OFF_ZERO;  end
            STEP_W'(8): begin dr = OFF_PLUS;  dc = OFF_PLUS;  end
            default:    begin dr = OFF_ZERO;  dc = OFF_ZERO;  end
        endcase
    end

    assign nr    = step_coord(row_reg, dr, cfg.size);
    assign nc    = step_coord(col_reg, dc, cfg.size);
    assign nb_ok = nr.ok && nc.ok;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg.clear)
        begin
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                    if (clr_addr_reg == ADDR_W'(CELLS - 1))
                        state_next = ST_IDLE;
                ST_IDLE:
                    if (accept)
                        state_next = in_grid ? ST_READ : ST_DONE;
                ST_READ:
                    if (step_reg == last_step)
                        state_next = ST_LAST;
                ST_LAST:
                    state_next = ST_WRITE;
                ST_WRITE:
                    state_next = ST_DONE;
                ST_DONE:
                    if (res_free)
                        state_next = ST_IDLE;
                default:
                    state_next = ST_CLEAR;
            endcase
        end
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = {nr.pos, nc.pos};
        mem_wdata = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            ST_IDLE:
                in_ready = 1'b1;
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_addr  = {row_reg, col_reg};
                mem_wdata = nv_calc;
            end
            ST_DONE:
                res_valid = 1'b1;
            default:
                mem_we = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        step_next       = step_reg;
        kind_next       = kind_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        lv_next         = lv_reg;
        old_next        = old_reg;
        nv_next         = nv_reg;
        zero_cnt_next   = zero_cnt_reg;
        one_cnt_next    = one_cnt_reg;
        ones_next       = ones_reg;
        zero_wr_next    = zero_wr_reg;
        one_wr_next     = one_wr_reg;
        pend_valid_next = (state_reg == ST_READ);
        pend_tgt_next   = (step_reg == STEP_TARGET);
        pend_in_next    = nb_ok;

        // fold in the read that returns this cycle
        if (pend_valid_reg)
        begin
            if (pend_tgt_reg)
                old_next = mem_rdata_reg;
            else if (pend_in_reg && mem_rdata_reg)
                one_cnt_next = one_cnt_reg + NB_W'(1);
            else if (pend_in_reg)
                zero_cnt_next = zero_cnt_reg + NB_W'(1);
        end

        if (state_reg == ST_CLEAR)
            clr_addr_next = clr_addr_reg + ADDR_W'(1);

        if (accept)
        begin
            step_next     = STEP_TARGET;
            kind_next     = in_kind;
            row_next      = in_row;
            col_next      = in_column;
            lv_next       = in_load_value;
            nv_next       = 1'b0;
            zero_cnt_next = '0;
            one_cnt_next  = '0;
        end

        if (state_reg == ST_READ)
            step_next = step_reg + STEP_W'(1);

        // write-back: running ones count and saturating write counts
        if (state_reg == ST_WRITE)
        begin
            nv_next = nv_calc;
            if (nv_calc && !old_reg)
                ones_next = ones_reg + CNT_W'(1);
            else if (!nv_calc && old_reg)
                ones_next = ones_reg - CNT_W'(1);
            if (kind_reg == KIND_UPDATE)
            begin
                if (nv_calc && one_wr_reg != '1)
                    one_wr_next = one_wr_reg + WCNT_W'(1);
                else if (!nv_calc && zero_wr_reg != '1)
                    zero_wr_next = zero_wr_reg + WCNT_W'(1);
            end
        end

        if (cfg.clear)
        begin
            clr_addr_next = '0;
            ones_next     = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            step_reg       <= STEP_TARGET;
            ones_reg       <= '0;
            zero_wr_reg    <= '0;
            one_wr_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            step_reg       <= step_next;
            ones_reg       <= ones_next;
            zero_wr_reg    <= zero_wr_next;
            one_wr_reg     <= one_wr_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        lv_reg       <= lv_next;
        old_reg      <= old_next;
        nv_reg       <= nv_next;
        zero_cnt_reg <= zero_cnt_next;
        one_cnt_reg  <= one_cnt_next;
        pend_tgt_reg <= pend_tgt_next;
        pend_in_reg  <= pend_in_next;
    end

    // Grid memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        else
            mem_rdata_reg <= mem[mem_addr];
    end

    // Result
    assign res.new_value       = nv_reg;
    assign res.zero_neighbours = zero_cnt_reg;
    assign res.one_neighbours  = one_cnt_reg;
    assign res.ones_total      = ones_reg;
    assign res.uniform         = (ones_reg == '0) || (ones_reg == cfg.cells);
    assign res.zero_writes     = zero_wr_reg;
    assign res.one_writes      = one_wr_reg;

    // Checks
    a_ones_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg <= cfg.cells)
        else $error("ones count exceeds cells in use");

    a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> (state_reg == ST_CLEAR) && (clr_addr_reg == '0) && (ones_reg == '0))
        else $error("grid size write did not restart the clearing pass");

    a_nb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |->
            ((NB_W + 1)'(zero_cnt_reg) + (NB_W + 1)'(one_cnt_reg) <= (NB_W + 1)'(8)))
        else $error("more than eight neighbours counted");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_READ || state_reg == ST_WRITE) |-> !accept)
        else $error("item accepted while busy");

endmodule

>>> src/binary_grid_majority_update.sv
// Top level of the binary grid majority update block: ports, grid size
// register and output register. Depends on bgmu_pkg and bgmu_core.
`timescale 1ns / 1ps

// Keeps a 64 x 64 grid of one-bit cells. Each input transfer is a load of one
// cell (tuser 0) or a majority update of one cell from its in-grid eight
// neighbours (tuser 1); every input transfer gives exactly one output transfer
// with the new cell value, neighbour counts, ones total, uniform flag and the
// saturating write counts. The grid side is set through cfg_we/cfg_wdata,
// clamped to 3..64; a write clears the grid and the ones total.
// The grid sits in a single-port memory, so an update reads the addressed
// cell and its eight neighbours one per cycle, then writes back before the
// result goes to the output register; a load reads only the addressed cell
// before its write, and an address outside the grid skips the memory.
// One item is worked on at a time; s_tready is high only while the
// sequencer is idle. After reset, and after each grid size write, a
// clearing pass over all 4096 cells zeroes the memory with s_tready low;
// configuration writes are still taken. A result waits in the output
// register while m_tready is low; the sequencer then holds the next result
// and takes no new item until the register frees.

module binary_grid_majority_update (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: grid side
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row[5:0], column[11:6], load_value[12], zero[15:13]
    input  logic        s_tuser,   // kind
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // new_value[0], zero_neighbours[4:1],
                                   // one_neighbours[8:5], ones_total[21:9],
                                   // uniform[22], zero_writes[54:23],
                                   // one_writes[86:55], zero[87]
);
    import bgmu_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  cells_reg, cells_next;
    logic [2*SIZE_W-1:0] size_sq;
    cfg_t              cfg;

    logic              res_valid;
    logic              res_free;
    result_t           res;
    logic              m_valid_reg, m_valid_next;
    result_t           m_res_reg, m_res_next;

    // Clamp written side and precompute the number of cells in use
    always_comb
    begin
        size_next = size_reg;
        if (cfg_we)
        begin
            if (cfg_wdata < SIZE_MIN)
                size_next = SIZE_MIN;
            else if (cfg_wdata > SIZE_MAX)
                size_next = SIZE_MAX;
            else
                size_next = cfg_wdata;
        end
        size_sq    = {{SIZE_W{1'b0}}, size_next} * {{SIZE_W{1'b0}}, size_next};
        cells_next = size_sq[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_MAX;
            cells_reg <= CNT_W'(CELLS);
        end
        else
        begin
            size_reg  <= size_next;
            cells_reg <= cells_next;
        end
    end

    assign cfg.clear = cfg_we;
    assign cfg.size  = size_reg;
    assign cfg.cells = cells_reg;

    bgmu_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_row        (s_tdata[5:0]),
        .in_column     (s_tdata[11:6]),
        .in_load_value (s_tdata[12]),
        .res_valid     (res_valid),
        .res_free      (res_free),
        .res           (res)
    );

    // Output register
    assign res_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_free)
        begin
            m_valid_next = res_valid;
            if (res_valid)
                m_res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0,
                       m_res_reg.one_writes,
                       m_res_reg.zero_writes,
                       m_res_reg.uniform,
                       m_res_reg.ones_total,
                       m_res_reg.one_neighbours,
                       m_res_reg.zero_neighbours,
                       m_res_reg.new_value};

endmodule

>>> dv/binary_grid_majority_update_test.sv
// Self-checking testbench for binary_grid_majority_update: directed table, then random phases.
// Each transfer is checked field by field against a behavioural grid predictor or a table row.
// Depends on bgmu_pkg and binary_grid_majority_update.
`timescale 1ns / 1ps

module binary_grid_majority_update_test;

    import bgmu_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic {
        STIM_ITEM,
        STIM_SIZE
    } stim_op_t;

    // One directed step with the result fields that can be read off directly
    typedef struct {
        stim_op_t    op;
        logic        kind;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [6:0]  value;     // load bit, or grid side for a size write
        logic        new_value;
        logic [3:0]  zeros;
        logic [3:0]  ones;
        logic [12:0] total;
        logic        uniform;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [6:0]  cfg_wdata = 7'd64;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = KIND_LOAD;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;

    // Grid predictor state
    bit          grid_cells [GRID_MAX][GRID_MAX];
    int unsigned grid_side     = GRID_MAX;
    int unsigned ones_held     = 0;
    logic [31:0] zero_wr_count = '0;
    logic [31:0] one_wr_count  = '0;

    result_t     cell_results_q [$];
    int          fails = 0;

    // Literal overrides travel alongside the input transfer
    logic        lit_on = 1'b0;
    result_t     lit_r  = '0;

    // Idling controls
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;

    // Corner, edges, tie, out-of-grid and full-grid cases
    stim_row_t directed_rows [24] = '{
        '{STIM_ITEM, KIND_UPDATE,  0,  0, 0, 0, 3, 0, 0, 1},
        '{STIM_ITEM, KIND_LOAD,    0,  0, 1, 1, 0, 0, 1, 0},
        '{STIM_ITEM, KIND_LOAD,    0,  1, 1, 1, 0, 0, 2, 0},
        '{STIM_ITEM, KIND_LOAD,    1,  0, 1, 1, 0, 0, 3, 0},
        '{STIM_ITEM, KIND_LOAD,    0,  2, 1, 1, 0, 0, 4, 0},
        '{STIM_ITEM, KIND_UPDATE,  1,  1, 1, 0, 4, 4, 4, 0},   // four against four
        '{STIM_ITEM, KIND_UPDATE,  0,  0, 0, 1, 1, 2, 4, 0},
        '{STIM_ITEM, KIND_LOAD,   63, 63, 1, 1, 0, 0, 5, 0},
        '{STIM_ITEM, KIND_UPDATE, 63, 62, 0, 0, 4, 1, 5, 0},
        '{STIM_ITEM, KIND_UPDATE, 63, 63, 1, 0, 3, 0, 4, 0},
        '{STIM_SIZE, KIND_LOAD,    0,  0, 2, 0, 0, 0, 0, 0},   // below range, taken as 3
        '{STIM_ITEM, KIND_UPDATE,  1,  1, 0, 0, 8, 0, 0, 1},
        '{STIM_ITEM, KIND_LOAD,    0,  0, 1, 1, 0, 0, 1, 0},
        '{STIM_ITEM, KIND_LOAD,    0,  1, 1, 1, 0, 0, 2, 0},
        '{STIM_ITEM, KIND_LOAD,    0,  2, 1, 1, 0, 0, 3, 0},
        '{STIM_ITEM, KIND_LOAD,    1,  0, 1, 1, 0, 0, 4, 0},
        '{STIM_ITEM, KIND_LOAD,    1,  2, 1, 1, 0, 0, 5, 0},
        '{STIM_ITEM, KIND_LOAD,    2,  0, 1, 1, 0, 0, 6, 0},
        '{STIM_ITEM, KIND_LOAD,    2,  1, 1, 1, 0, 0, 7, 0},
        '{STIM_ITEM, KIND_LOAD,    2,  2, 1, 1, 0, 0, 8, 0},
        '{STIM_ITEM, KIND_UPDATE,  1,  1, 0, 1, 0, 8, 9, 1},
        '{STIM_ITEM, KIND_UPDATE,  3,  0, 0, 0, 0, 0, 9, 1},   // row outside the grid
        '{STIM_ITEM, KIND_LOAD,    0, 63, 1, 0, 0, 0, 9, 1},   // column outside the grid
        '{STIM_ITEM, KIND_LOAD,    2,  2, 0, 0, 0, 0, 8, 0}
    };

    // Random phases: grid side written, idling mode from the phase number
    int unsigned phase_side [8] = '{127, 3, 5, 64, 1, 12, 64, 33};
    int          phase_send [4] = '{0, 53, 0, 16};
    int          phase_stall [4] = '{0, 0, 53, 16};

    binary_grid_majority_update DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // Grid side write: clamp, clear every cell and the ones total
    function automatic void set_grid_side(input logic [6:0] v);
        if (v < SIZE_MIN)
            grid_side = 32'(SIZE_MIN);
        else if (v > SIZE_MAX)
            grid_side = 32'(SIZE_MAX);
        else
            grid_side = 32'(v);
        foreach (grid_cells[r, c])
            grid_cells[r][c] = 1'b0;
        ones_held = 0;
    endfunction

    // Load or majority update of one cell; returns the result it gives
    function automatic result_t apply_cell_item(input logic k, input logic [5:0] r,
                                                input logic [5:0] c, input logic lv);
        result_t     res;
        int          dr;
        int          dc;
        int          nr;
        int          nc;
        int unsigned zc;
        int unsigned oc;
        res = '0;
        zc  = 0;
        oc  = 0;
        if (r < grid_side && c < grid_side)
        begin
            if (k == KIND_LOAD)
                res.new_value = lv;
            else
            begin
                for (dr = -1; dr <= 1; dr++)
                    for (dc = -1; dc <= 1; dc++)
                    begin
                        nr = int'(r) + dr;
                        nc = int'(c) + dc;
                        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 &&
                            nr < int'(grid_side) && nc < int'(grid_side))
                        begin
                            if (grid_cells[nr][nc])
                                oc++;
                            else
                                zc++;
                        end
                    end
                res.new_value = (oc > zc);
                if (res.new_value)
                begin
                    if (one_wr_count != '1)
                        one_wr_count++;
                end
                else if (zero_wr_count != '1)
                    zero_wr_count++;
            end
            if (grid_cells[r][c] != res.new_value)
                ones_held = res.new_value ? ones_held + 1 : ones_held - 1;
            grid_cells[r][c] = res.new_value;
        end
        res.zero_neighbours = NB_W'(zc);
        res.one_neighbours  = NB_W'(oc);
        res.ones_total      = CNT_W'(ones_held);
        res.uniform         = (ones_held == 0) || (ones_held == grid_side * grid_side);
        res.zero_writes     = zero_wr_count;
        res.one_writes      = one_wr_count;
        return res;
    endfunction

    // Mostly near the low and high edges, sometimes anywhere, sometimes outside the grid
    function automatic logic [5:0] pick_coord();
        int unsigned reach;
        reach = (grid_side > 6) ? 5 : grid_side - 1;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 6'($urandom_range(reach));
            6, 7:             return 6'(grid_side - 1 - $urandom_range(reach));
            8:                return 6'($urandom_range(grid_side - 1));
            default:          return 6'($urandom_range(63));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            fails++;
        end
    endtask

    // Offer one input transfer after a random gap; returns once it is taken
    task automatic send_item(input logic k, input logic [5:0] r, input logic [5:0] c,
                             input logic lv, input logic lit, input result_t lit_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {3'b000, lv, c, r};
        lit_on   <= lit;
        lit_r    <= lit_val;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Grid side written only once every result is back
    task automatic write_grid_side(input logic [6:0] v);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (cell_results_q.size() != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        set_grid_side(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Predict on each input transfer, compare each output transfer
    always @(posedge clk)
    begin : watch
        result_t want;
        result_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            want = apply_cell_item(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[12]);
            if (lit_on)
            begin
                want.new_value       = lit_r.new_value;
                want.zero_neighbours = lit_r.zero_neighbours;
                want.one_neighbours  = lit_r.one_neighbours;
                want.ones_total      = lit_r.ones_total;
                want.uniform         = lit_r.uniform;
            end
            cell_results_q.push_back(want);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cell_results_q.size() == 0)
            begin
                $display("%0t ns: unexpected result transfer, expected none, actual %h",
                         $time, m_tdata);
                fails++;
            end
            else
            begin
                want                = cell_results_q.pop_front();
                got.new_value       = m_tdata[0];
                got.zero_neighbours = m_tdata[4:1];
                got.one_neighbours  = m_tdata[8:5];
                got.ones_total      = m_tdata[21:9];
                got.uniform         = m_tdata[22];
                got.zero_writes     = m_tdata[54:23];
                got.one_writes      = m_tdata[86:55];
                check_field("new_value", 32'(want.new_value), 32'(got.new_value));
                check_field("zero_neighbours", 32'(want.zero_neighbours),
                            32'(got.zero_neighbours));
                check_field("one_neighbours", 32'(want.one_neighbours),
                            32'(got.one_neighbours));
                check_field("ones_total", 32'(want.ones_total), 32'(got.ones_total));
                check_field("uniform", 32'(want.uniform), 32'(got.uniform));
                check_field("zero_writes", want.zero_writes, got.zero_writes);
                check_field("one_writes", want.one_writes, got.one_writes);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t step;
        result_t   lit_val;
        int        n;
        int        p;
        int        i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (n = 0; n < $size(directed_rows); n++)
        begin
            step = directed_rows[n];
            if (step.op == STIM_SIZE)
                write_grid_side(step.value);
            else
            begin
                lit_val                 = '0;
                lit_val.new_value       = step.new_value;
                lit_val.zero_neighbours = step.zeros;
                lit_val.one_neighbours  = step.ones;
                lit_val.ones_total      = step.total;
                lit_val.uniform         = step.uniform;
                send_item(step.kind, step.row, step.col, step.value[0], 1'b1, lit_val);
            end
        end

        // Random phases
        lit_val = '0;
        for (p = 0; p < $size(phase_side); p++)
        begin
            write_grid_side(7'(phase_side[p]));
            send_idle_pct = phase_send[p % 4];
            stall_pct     = phase_stall[p % 4];
            for (i = 0; i < 56; i++)
            begin
                // long result hold-off while the sender keeps offering
                if (p == 0 && i == 16)
                    hold_requests++;
                send_item(1'($urandom_range(1)), pick_coord(), pick_coord(),
                          1'($urandom_range(1)), 1'b0, lit_val);
            end
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (cell_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
